// ===== rtl/cpce_pkg.sv =====
// Package for the control point curve evaluator.
// Holds shared widths, codes and the controller/datapath command types.
package cpce_pkg;

  localparam int XW = 17;
  localparam int YW = 18;
  localparam int CW = 5;
  localparam int DEF_MAX_POINTS = 16;

  localparam logic [XW-1:0] ONE_Q16 = XW'(65536);
  localparam logic signed [YW-1:0] HALF_Q16 = YW'(32768);
  localparam logic signed [YW-1:0] Y_MAX = YW'(131071);
  localparam logic signed [YW-1:0] Y_MIN = -YW'(131072);

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_EVAL   = 2'd2;

  localparam logic [1:0] REG_CURVE_KIND   = 2'd0;
  localparam logic [1:0] REG_CLAMP_RESULT = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic clear;      // empty the table
    logic shift;      // move entry ptr-1 up to ptr, step ptr down
    logic place;      // write the new point at ptr, bump count
    logic scan;       // compare eval x against entry ptr, step ptr up
    logic setup;      // build the division operands
    logic div_step;   // one restoring division step
    logic finish;     // form the result
  } cpce_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;       // table holds MAX_POINTS entries
    logic empty;      // table holds no entries
    logic shift_more; // entry below ptr exceeds the new x
    logic scan_hit;   // eval x at or below entry ptr, or scan ran out
    logic div_done;   // last division step taken
  } cpce_stat_t;

endpackage

// ===== rtl/cpce_if.sv =====
// Valid/ready channel interface used by both sides of the curve evaluator.
// Depends on cpce_pkg.
interface cpce_in_if import cpce_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [XW-1:0] point_x;
  logic signed [YW-1:0] point_y;
  logic [XW-1:0] eval_x;
  modport source (output valid, mode, point_x, point_y, eval_x, input ready);
  modport sink (input valid, mode, point_x, point_y, eval_x, output ready);
endinterface

interface cpce_out_if import cpce_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [YW-1:0] curve_value;
  logic status;
  logic [CW-1:0] points_held;
  modport source (output valid, curve_value, status, points_held, input ready);
  modport sink (input valid, curve_value, status, points_held, output ready);
endinterface

// ===== rtl/cpce_datapath.sv =====
// Datapath: knot tables, insertion shifter, segment scan and serial divider.
// Depends on cpce_pkg; driven by cpce_ctrl commands.
module cpce_datapath import cpce_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic clk,
  input  logic rst,
  input  cpce_cmd_t cmd,
  output cpce_stat_t stat,
  input  logic [1:0] in_mode,
  input  logic [XW-1:0] in_px,
  input  logic signed [YW-1:0] in_py,
  input  logic [XW-1:0] in_ex,
  input  logic curve_kind,
  input  logic clamp_result,
  output logic signed [YW-1:0] res_value,
  output logic [CW-1:0] res_count
);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int DW = XW + 2;        // signed span and offset width
  localparam int MW = YW + 1 + DW;   // product width
  localparam int QB = MW + 2;        // dividend bits walked

  logic [XW-1:0] kx [MAX_POINTS];
  logic signed [YW-1:0] ky [MAX_POINTS];
  logic [NW-1:0] count;
  logic [NW-1:0] ptr;
  logic [1:0] mode;
  logic [XW-1:0] px, ex;
  logic signed [YW-1:0] py;
  logic [XW-1:0] rd_x, rdm_x;
  logic signed [YW-1:0] rd_y, rdm_y;
  logic [PW-1:0] pi, pim;

  // segment endpoints chosen by scan
  logic signed [DW-1:0] ax, bx;
  logic signed [YW-1:0] ay, by;
  logic direct;                    // result known without division
  logic signed [YW-1:0] direct_val;
  logic neg;
  logic [QB-1:0] dvd;
  logic [DW:0] dvs;
  logic [QB-1:0] quo;
  logic [DW+1:0] rem;
  logic [$clog2(QB+1)-1:0] step;
  logic signed [MW-1:0] prod;
  logic signed [MW-1:0] prod_abs;

  assign pi  = ptr[PW-1:0];
  assign pim = PW'(ptr - NW'(1));
  assign rd_x = kx[pi];
  assign rd_y = ky[pi];
  assign rdm_x = kx[pim];
  assign rdm_y = ky[pim];

  assign stat.full = (count == NW'(MAX_POINTS));
  assign stat.empty = (count == '0);
  assign stat.shift_more = (ptr != '0) && (rdm_x > px);
  // a hue curve takes x equal to the first knot from the first segment, not the wrap
  assign stat.scan_hit = (ptr >= count) || (ex < rd_x) ||
                         ((ex == rd_x) && !(curve_kind && ptr == '0));
  assign stat.div_done = (step == '0);
  assign res_count = CW'(count);

  logic signed [DW-1:0] den_c, off_c;
  logic [DW+1:0] rem_sh;
  assign den_c = bx - ax;
  assign off_c = DW'($signed({1'b0, ex})) - ax;
  assign rem_sh = {rem[DW:0], dvd[QB-1]};
  assign prod_abs = (prod < 0) ? -prod : prod;

  logic signed [YW+2:0] sum;
  always_comb begin
    sum = (YW+3)'(ay) + (neg ? -(YW+3)'($signed({1'b0, quo})) :
                               (YW+3)'($signed({1'b0, quo})));
    if (quo > QB'(Y_MAX) + QB'(Y_MAX))
      sum = neg ? (YW+3)'(Y_MIN) - (YW+3)'(1) : (YW+3)'(Y_MAX) + (YW+3)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.clear) count <= '0;
      if (cmd.place) count <= count + NW'(1);
    end
    if (cmd.load) begin
      mode <= in_mode;
      px <= in_px;
      py <= in_py;
      ex <= in_ex;
      ptr <= (in_mode == MODE_INSERT) ? count : '0;
    end
    if (cmd.shift) begin
      kx[pi] <= rdm_x;
      ky[pi] <= rdm_y;
      ptr <= ptr - NW'(1);
    end
    if (cmd.place) begin
      kx[pi] <= px;
      ky[pi] <= py;
    end
    if (cmd.scan) begin
      if (!stat.scan_hit) ptr <= ptr + NW'(1);
      // endpoints of the current candidate segment
      if (ptr == '0) begin
        ax <= DW'($signed({1'b0, kx[PW'(count - NW'(1))]})) - DW'($signed({1'b0, ONE_Q16}));
        ay <= ky[PW'(count - NW'(1))];
      end else begin
        ax <= DW'($signed({1'b0, rdm_x}));
        ay <= rdm_y;
      end
      if (ptr >= count) begin
        bx <= DW'($signed({1'b0, kx[0]})) + DW'($signed({1'b0, ONE_Q16}));
        by <= ky[0];
      end else begin
        bx <= DW'($signed({1'b0, rd_x}));
        by <= rd_y;
      end
      if (stat.scan_hit) begin
        if (mode != MODE_EVAL) begin
          direct <= 1'b1; direct_val <= '0;
        end else if (count == '0) begin
          direct <= 1'b1;
          direct_val <= curve_kind ? HALF_Q16 :
                        (ex > ONE_Q16 ? YW'(ONE_Q16) : YW'(ex));
        end else if (!curve_kind && ptr == '0) begin
          direct <= 1'b1; direct_val <= rd_y;
        end else if (!curve_kind &&
                     (ptr >= count || ex >= kx[PW'(count - NW'(1))])) begin
          // at or past the last knot, hold the last y
          direct <= 1'b1; direct_val <= ky[PW'(count - NW'(1))];
        end else begin
          direct <= 1'b0;
        end
      end
    end
    if (cmd.setup) begin
      prod <= MW'(by - ay) * MW'(off_c);
      dvs <= (DW+1)'(den_c < 0 ? -den_c : den_c);
      neg <= (den_c < 0);
      if (den_c == '0 && !direct) begin
        direct <= 1'b1; direct_val <= ay;
      end
      step <= ($clog2(QB+1))'(QB + 1);
    end
    if (cmd.div_step) begin
      if (step == ($clog2(QB+1))'(QB + 1)) begin
        // rounding: (2|num| + d) / (2d)
        dvd <= QB'({prod_abs, 1'b0}) + QB'(dvs);
        dvs <= {dvs[DW-1:0], 1'b0};
        neg <= neg ^ (prod < 0);
        rem <= '0;
        quo <= '0;
      end else begin
        if (rem_sh >= (DW+2)'(dvs)) begin
          rem <= rem_sh - (DW+2)'(dvs);
          quo <= {quo[QB-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[QB-2:0], 1'b0};
        end
        dvd <= {dvd[QB-2:0], 1'b0};
      end
      step <= step - 1'b1;
    end
    if (cmd.finish) begin
      logic signed [YW-1:0] v;
      v = direct ? direct_val :
          (sum > (YW+3)'(Y_MAX) ? Y_MAX : (sum < (YW+3)'(Y_MIN) ? Y_MIN : YW'(sum)));
      if (mode == MODE_EVAL && clamp_result) begin
        if (v < 0) v = '0;
        else if (v > $signed(YW'(ONE_Q16))) v = YW'(ONE_Q16);
      end
      res_value <= v;
    end
  end
endmodule

// ===== rtl/cpce_ctrl.sv =====
// Controller state machine: sequences insert, scan and division per item.
// Depends on cpce_pkg; commands cpce_datapath.
module cpce_ctrl import cpce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_mode,
  output logic out_valid,
  input  logic out_ready,
  output logic res_status,
  input  logic direct_hint,
  input  cpce_stat_t stat,
  output cpce_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SCAN, S_SETUP, S_DIV, S_FIN, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);
  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.clear = cmd.load && (in_mode == MODE_CLEAR);
    cmd.shift = (state == S_SHIFT) && stat.shift_more;
    cmd.place = (state == S_SHIFT) && !stat.shift_more;
    cmd.scan = (state == S_SCAN);
    cmd.setup = (state == S_SETUP);
    cmd.div_step = (state == S_DIV) && !stat.div_done;
    cmd.finish = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      res_status <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_status <= (in_mode == MODE_INSERT) && stat.full;
            if (in_mode == MODE_INSERT && !stat.full) state <= S_SHIFT;
            else state <= S_SCAN;
          end
        end
        S_SHIFT: if (!stat.shift_more) state <= S_SCAN;
        S_SCAN: if (stat.scan_hit) state <= S_SETUP;
        S_SETUP: state <= S_DIV;
        S_DIV: if (stat.div_done || direct_hint) state <= S_FIN;
        S_FIN: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/control_point_curve_evaluator.sv =====
// Control point curve evaluator: top level with APB register port.
// One item at a time. Every item is first accepted; an insert then moves each
// larger point up one place and places the new point. Every item then scans
// 1 to (points + 1) table entries, builds the division operands in a setup step,
// runs the bit-serial divider that rounds the interpolation quotient and forms
// the result in a finish step; a held result blocks the next item.
// Depends on cpce_pkg, cpce_if, cpce_ctrl, cpce_datapath.
module control_point_curve_evaluator import cpce_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic clk,
  input  logic rst,
  cpce_in_if.sink  in_ch,
  cpce_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic curve_kind, clamp_result;
  cpce_cmd_t cmd;
  cpce_stat_t stat;
  logic direct;

  assign pready = 1'b1;
  // register writes land at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind <= 1'b0;
      clamp_result <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CLAMP_RESULT[0]) clamp_result <= pwdata[0];
      else curve_kind <= pwdata[0];
    end
  end
  always_comb begin
    prdata = '0;
    prdata[0] = paddr[2] ? clamp_result : curve_kind;
  end

  assign direct = 1'b0;

  cpce_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .res_status(out_ch.status),
    .direct_hint(direct), .stat, .cmd
  );

  cpce_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_mode(in_ch.mode), .in_px(in_ch.point_x), .in_py(in_ch.point_y),
    .in_ex(in_ch.eval_x), .curve_kind, .clamp_result,
    .res_value(out_ch.curve_value), .res_count(out_ch.points_held)
  );

  // hold the result steady while it waits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.curve_value))
    else $error("result changed while stalled");
  // no new item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input open with result pending");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_ch.points_held <= CW'(MAX_POINTS)) else $error("count overflow");
endmodule
